>>> hdl/cit_pkg.sv
// Shared constants for the circle intersection third-point block.
package cit_pkg;
    localparam int COORD_WIDTH_DEF = 32;
endpackage

>>> hdl/circle_intersection_third_point.sv
// Top level: third point of a triangle from two circles, fully pipelined.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_      | in  | first_x, first_y, second_x, second_y, base_length,   | -
//          |     | radius_first, radius_second, zero pad to bytes       |
//  m_      | out | sol_a_x, sol_a_y, sol_b_x, sol_b_y                   | valid_res
//
// One request per cycle while s_tready is high; the pipeline depth is set by the
// one-bit-per-stage dividers for a and the four offset terms and the root pipeline.
// aresetn is synchronous, active low, and clears only valid bits.
// A two-entry output register and skid stage decouple m_tready from the pipeline;
// the pipeline freezes only while the skid entry is occupied.
module circle_intersection_third_point #(
    parameter int COORD_WIDTH = cit_pkg::COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // first_x, first_y, second_x, second_y, base_length, radius_first, radius_second
    input  logic [((7*COORD_WIDTH-3+7)/8)*8-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // sol_a_x, sol_a_y, sol_b_x, sol_b_y
    output logic [4*COORD_WIDTH-1:0] m_tdata,
    // valid_res
    output logic                   m_tuser
);
    localparam int W     = COORD_WIDTH;
    localparam int L     = W - 1;
    localparam int SQ_W  = 2 * L;
    localparam int P_W   = 2 * L + 1;
    localparam int PR_W  = L + W;
    localparam int TS_W  = PR_W + 1;
    localparam int SUM_W = TS_W + 2;

    typedef struct packed {
        logic [SQ_W-1:0]     r0sq;
        logic [L-1:0]        r0;
        logic [L-1:0]        d;
        logic signed [W:0]   dx;
        logic signed [W:0]   dy;
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
        logic                aneg;
        logic                dz;
    } side_a_t;

    typedef struct packed {
        logic [L-1:0]        a;
        logic                aneg;
        logic                bad;
        logic [L-1:0]        d;
        logic signed [W:0]   dx;
        logic signed [W:0]   dy;
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
    } side_h_t;

    typedef struct packed {
        logic                na_x;
        logic                bad;
        logic signed [W-1:0] x0;
        logic signed [W-1:0] y0;
    } side_t_t;

    typedef struct packed {
        logic                valid_res;
        logic signed [W-1:0] sby;
        logic signed [W-1:0] sbx;
        logic signed [W-1:0] say;
        logic signed [W-1:0] sax;
    } res_t;

    function automatic logic signed [W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-W:0] hi;
        logic signed [W-1:0] r;
        hi = v[SUM_W-1:W-1];
        if (hi == '0 || hi == '1) begin
            r = v[W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage 0: input capture
    logic                s0_valid_reg;
    logic signed [W-1:0] s0_x0_reg, s0_y0_reg, s0_x1_reg, s0_y1_reg;
    logic [L-1:0]        s0_d_reg, s0_r0_reg, s0_r1_reg;

    // stage 1: squares and deltas
    logic                s1_valid_reg;
    logic [SQ_W-1:0]     s1_r0sq_reg, s1_dsq_reg, s1_r1sq_reg;
    logic signed [W:0]   s1_dx_reg, s1_dy_reg;
    logic signed [W-1:0] s1_x0_reg, s1_y0_reg;
    logic [L-1:0]        s1_d_reg, s1_r0_reg;

    // stage 2: numerator of a
    logic                s2_valid_reg;
    logic [P_W-1:0]      s2_num_reg;
    logic [L:0]          s2_den_reg;
    side_a_t             s2_side_reg;

    logic [P_W:0]        s1_p;
    logic [P_W:0]        s1_diff;

    always_comb begin
        s1_p    = {2'b00, s1_r0sq_reg} + {2'b00, s1_dsq_reg};
        s1_diff = s1_p - {2'b00, s1_r1sq_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_tvalid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_x0_reg <= s_tdata[W-1:0];
            s0_y0_reg <= s_tdata[2*W-1:W];
            s0_x1_reg <= s_tdata[3*W-1:2*W];
            s0_y1_reg <= s_tdata[4*W-1:3*W];
            s0_d_reg  <= s_tdata[4*W+L-1:4*W];
            s0_r0_reg <= s_tdata[4*W+2*L-1:4*W+L];
            s0_r1_reg <= s_tdata[4*W+3*L-1:4*W+2*L];

            s1_r0sq_reg <= s0_r0_reg * s0_r0_reg;
            s1_dsq_reg  <= s0_d_reg * s0_d_reg;
            s1_r1sq_reg <= s0_r1_reg * s0_r1_reg;
            s1_dx_reg   <= (W+1)'(s0_x1_reg) - (W+1)'(s0_x0_reg);
            s1_dy_reg   <= (W+1)'(s0_y1_reg) - (W+1)'(s0_y0_reg);
            s1_x0_reg   <= s0_x0_reg;
            s1_y0_reg   <= s0_y0_reg;
            s1_d_reg    <= s0_d_reg;
            s1_r0_reg   <= s0_r0_reg;

            s2_num_reg       <= s1_diff[P_W] ? P_W'(-s1_diff) : s1_diff[P_W-1:0];
            s2_den_reg       <= {s1_d_reg, 1'b0};
            s2_side_reg.r0sq <= s1_r0sq_reg;
            s2_side_reg.r0   <= s1_r0_reg;
            s2_side_reg.d    <= s1_d_reg;
            s2_side_reg.dx   <= s1_dx_reg;
            s2_side_reg.dy   <= s1_dy_reg;
            s2_side_reg.x0   <= s1_x0_reg;
            s2_side_reg.y0   <= s1_y0_reg;
            s2_side_reg.aneg <= s1_diff[P_W];
            s2_side_reg.dz   <= (s1_d_reg == '0);
        end
    end

    // a = |r0^2 + d^2 - r1^2| / 2d
    logic                divA_valid;
    logic [P_W-1:0]      divA_quot;
    logic [$bits(side_a_t)-1:0] divA_side_vec;
    side_a_t             divA_side;

    cit_div_pipe #(
        .NUM_W (P_W),
        .DEN_W (L + 1),
        .SIDE_W($bits(side_a_t))
    ) u_div_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s2_valid_reg),
        .num      (s2_num_reg),
        .den      (s2_den_reg),
        .side     (s2_side_reg),
        .out_valid(divA_valid),
        .quot     (divA_quot),
        .side_o   (divA_side_vec)
    );

    assign divA_side = side_a_t'(divA_side_vec);

    // stage 3: range check and a^2; stage 4: h^2
    logic                s3_valid_reg;
    logic [SQ_W-1:0]     s3_asq_reg, s3_r0sq_reg;
    side_h_t             s3_side_reg;
    logic                s4_valid_reg;
    logic [SQ_W-1:0]     s4_hsq_reg;
    side_h_t             s4_side_reg;

    logic                s2_bad;
    logic [L-1:0]        s2_a;

    always_comb begin
        s2_bad = divA_side.dz || (divA_quot > P_W'(divA_side.r0));
        s2_a   = divA_quot[L-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= divA_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_asq_reg       <= s2_a * s2_a;
            s3_r0sq_reg      <= divA_side.r0sq;
            s3_side_reg.a    <= s2_a;
            s3_side_reg.aneg <= divA_side.aneg && (s2_a != '0);
            s3_side_reg.bad  <= s2_bad;
            s3_side_reg.d    <= divA_side.d;
            s3_side_reg.dx   <= divA_side.dx;
            s3_side_reg.dy   <= divA_side.dy;
            s3_side_reg.x0   <= divA_side.x0;
            s3_side_reg.y0   <= divA_side.y0;

            s4_hsq_reg  <= s3_side_reg.bad ? '0 : (s3_r0sq_reg - s3_asq_reg);
            s4_side_reg <= s3_side_reg;
        end
    end

    logic                sq_valid;
    logic [L-1:0]        sq_root;
    logic [$bits(side_h_t)-1:0] sq_side_vec;
    side_h_t             sq_side;

    cit_sqrt_pipe #(
        .ROOT_W(L),
        .SIDE_W($bits(side_h_t))
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s4_valid_reg),
        .rad      (s4_hsq_reg),
        .side     (s4_side_reg),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_o   (sq_side_vec)
    );

    assign sq_side = side_h_t'(sq_side_vec);

    // stage 5: offset products
    logic                s5_valid_reg;
    logic [PR_W-1:0]     s5_pax_reg, s5_pay_reg, s5_phy_reg, s5_phx_reg;
    logic                s5_nay_reg, s5_nhy_reg, s5_nhx_reg;
    logic [L-1:0]        s5_d_reg;
    side_t_t             s5_side_reg;

    logic [W:0]          dx_abs, dy_abs;

    always_comb begin
        dx_abs = sq_side.dx[W] ? (W+1)'(-sq_side.dx) : sq_side.dx;
        dy_abs = sq_side.dy[W] ? (W+1)'(-sq_side.dy) : sq_side.dy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s5_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_pax_reg       <= sq_side.a * dx_abs[W-1:0];
            s5_pay_reg       <= sq_side.a * dy_abs[W-1:0];
            s5_phy_reg       <= sq_root * dy_abs[W-1:0];
            s5_phx_reg       <= sq_root * dx_abs[W-1:0];
            s5_nay_reg       <= sq_side.aneg ^ sq_side.dy[W];
            s5_nhy_reg       <= sq_side.dy[W];
            s5_nhx_reg       <= sq_side.dx[W];
            s5_d_reg         <= sq_side.d;
            s5_side_reg.na_x <= sq_side.aneg ^ sq_side.dx[W];
            s5_side_reg.bad  <= sq_side.bad;
            s5_side_reg.x0   <= sq_side.x0;
            s5_side_reg.y0   <= sq_side.y0;
        end
    end

    // four terms divided by d
    logic                tq_valid;
    logic [PR_W-1:0]     q_ax, q_ay, q_hy, q_hx;
    logic [$bits(side_t_t)-1:0] tq_side_vec;
    side_t_t             tq_side;
    logic                tq_nay, tq_nhy, tq_nhx;

    cit_div_pipe #(.NUM_W(PR_W), .DEN_W(L), .SIDE_W($bits(side_t_t))) u_div_ax (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s5_valid_reg),
        .num(s5_pax_reg), .den(s5_d_reg), .side(s5_side_reg),
        .out_valid(tq_valid), .quot(q_ax), .side_o(tq_side_vec)
    );

    cit_div_pipe #(.NUM_W(PR_W), .DEN_W(L), .SIDE_W(1)) u_div_ay (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s5_valid_reg),
        .num(s5_pay_reg), .den(s5_d_reg), .side(s5_nay_reg),
        .out_valid(), .quot(q_ay), .side_o(tq_nay)
    );

    cit_div_pipe #(.NUM_W(PR_W), .DEN_W(L), .SIDE_W(1)) u_div_hy (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s5_valid_reg),
        .num(s5_phy_reg), .den(s5_d_reg), .side(s5_nhy_reg),
        .out_valid(), .quot(q_hy), .side_o(tq_nhy)
    );

    cit_div_pipe #(.NUM_W(PR_W), .DEN_W(L), .SIDE_W(1)) u_div_hx (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(s5_valid_reg),
        .num(s5_phx_reg), .den(s5_d_reg), .side(s5_nhx_reg),
        .out_valid(), .quot(q_hx), .side_o(tq_nhx)
    );

    assign tq_side = side_t_t'(tq_side_vec);

    // stage 6: midpoint; stage 7: solution sums; stage 8: saturation
    logic                   s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic signed [SUM_W-1:0] s6_mx_reg, s6_my_reg;
    logic signed [TS_W-1:0]  s6_thy_reg, s6_thx_reg;
    logic                   s6_bad_reg, s7_bad_reg;
    logic signed [SUM_W-1:0] s7_sax_reg, s7_say_reg, s7_sbx_reg, s7_sby_reg;
    res_t                   s8_res_reg;

    logic signed [TS_W-1:0] t_ax, t_ay, t_hy, t_hx;

    always_comb begin
        t_ax = tq_side.na_x ? -$signed({1'b0, q_ax}) : $signed({1'b0, q_ax});
        t_ay = tq_nay ? -$signed({1'b0, q_ay}) : $signed({1'b0, q_ay});
        t_hy = tq_nhy ? -$signed({1'b0, q_hy}) : $signed({1'b0, q_hy});
        t_hx = tq_nhx ? -$signed({1'b0, q_hx}) : $signed({1'b0, q_hx});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end else if (en) begin
            s6_valid_reg <= tq_valid;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_mx_reg  <= SUM_W'(tq_side.x0) + SUM_W'(t_ax);
            s6_my_reg  <= SUM_W'(tq_side.y0) + SUM_W'(t_ay);
            s6_thy_reg <= t_hy;
            s6_thx_reg <= t_hx;
            s6_bad_reg <= tq_side.bad;

            s7_sax_reg <= s6_mx_reg + SUM_W'(s6_thy_reg);
            s7_say_reg <= s6_my_reg - SUM_W'(s6_thx_reg);
            s7_sbx_reg <= s6_mx_reg - SUM_W'(s6_thy_reg);
            s7_sby_reg <= s6_my_reg + SUM_W'(s6_thx_reg);
            s7_bad_reg <= s6_bad_reg;

            s8_res_reg.valid_res <= !s7_bad_reg;
            s8_res_reg.sax       <= s7_bad_reg ? '0 : sat(s7_sax_reg);
            s8_res_reg.say       <= s7_bad_reg ? '0 : sat(s7_say_reg);
            s8_res_reg.sbx       <= s7_bad_reg ? '0 : sat(s7_sbx_reg);
            s8_res_reg.sby       <= s7_bad_reg ? '0 : sat(s7_sby_reg);
        end
    end

    // output register and skid entry
    logic out_valid_reg;
    res_t out_res_reg;
    res_t skid_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_tready) begin
            if (en && s8_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_tready) begin
            if (en && s8_valid_reg) begin
                skid_res_reg <= s8_res_reg;
            end
        end else if (skid_valid_reg) begin
            out_res_reg <= skid_res_reg;
        end else begin
            out_res_reg <= s8_res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.sby, out_res_reg.sbx, out_res_reg.say, out_res_reg.sax};
    assign m_tuser  = out_res_reg.valid_res;
endmodule

>>> hdl/cit_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband delay.
module cit_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 31,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quot,
    output logic [SIDE_W-1:0] side_o
);
    logic              vld_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  work_reg [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              vld_prev;
        logic [DEN_W-1:0]  rem_prev;
        logic [NUM_W-1:0]  work_prev;
        logic [DEN_W-1:0]  den_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  work_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign work_prev = num;
            assign den_prev  = den;
            assign side_prev = side;
        end else begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign work_prev = work_reg[k-1];
            assign den_prev  = den_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            trial     = {rem_prev, work_prev[NUM_W-1]};
            ge        = (trial >= {1'b0, den_prev});
            diff      = trial - {1'b0, den_prev};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            work_next = {work_prev[NUM_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= den_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quot      = work_reg[NUM_W-1];
    assign side_o    = side_reg[NUM_W-1];
endmodule

>>> hdl/cit_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with sideband delay.
module cit_sqrt_pipe #(
    parameter int ROOT_W = 31,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] rad,
    input  logic [SIDE_W-1:0]   side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [SIDE_W-1:0]   side_o
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              vld_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W+1:0]  acc;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
            assign side_prev = side;
        end else begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb begin
            acc       = {rem_prev, rad_prev[RAD_W-1:RAD_W-2]};
            trial     = {2'b00, root_prev, 2'b01};
            ge        = (acc >= trial);
            diff      = acc - trial;
            rem_next  = ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
            root_next = {root_prev[ROOT_W-2:0], ge};
            rad_next  = {rad_prev[RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_o    = side_reg[ROOT_W-1];
endmodule

>>> hdl/cit_checker.sv
// Port-level checks for the circle intersection block, bound to the top level.
module cit_checker #(
    parameter int COORD_WIDTH = cit_pkg::COORD_WIDTH_DEF
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [4*COORD_WIDTH-1:0] m_tdata,
    input logic                     m_tuser
);
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result carries nonzero coordinates");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && !s_tready |=> !s_tready && m_tvalid)
        else $error("skid entry released while output stalled");

    a_accept_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
endmodule

bind circle_intersection_third_point cit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cit_checker (.*);
